>>> design/acdc_pkg.sv
// ----------------------------------------------------------------------------
// acdc_pkg: shared types and constants of the airbag crash-deploy controller
// Holds the mode codes, the fixed firing constants and the structs that pass
// between the controller's top level and its decision logic.
// ----------------------------------------------------------------------------
package acdc_pkg;

	localparam int NUM_AIRBAGS = 8;

	// Fixed rule constants in the sensor units (0.1 km/h, 0.1 g, 0.1 deg/s).
	localparam logic [15:0] LOW_SPEED_LIMIT   = 16'd50;
	localparam logic [15:0] SIDE_FIRE_ACCEL   = 16'd100;
	localparam logic [16:0] ROLL_CURTAIN_RATE = 17'd900;

	// Airbag bit positions.
	localparam int BAG_DRV_FRONT   = 0;
	localparam int BAG_PAS_FRONT   = 1;
	localparam int BAG_DRV_THORAX  = 2;
	localparam int BAG_PAS_THORAX  = 3;
	localparam int BAG_DRV_CURTAIN = 4;
	localparam int BAG_PAS_CURTAIN = 5;
	localparam int BAG_DRV_KNEE    = 6;
	localparam int BAG_PAS_KNEE    = 7;

	// Configuration register indexes.
	localparam logic [2:0] REG_FRONT_CRASH_DECEL  = 3'd0;
	localparam logic [2:0] REG_FRONT_CRASH_SPEED  = 3'd1;
	localparam logic [2:0] REG_SIDE_CRASH_ACCEL   = 3'd2;
	localparam logic [2:0] REG_SIDE_CRASH_SPEED   = 3'd3;
	localparam logic [2:0] REG_ROLLOVER_RATE      = 3'd4;
	localparam logic [2:0] REG_ROLLOVER_VERTICAL  = 3'd5;
	localparam logic [2:0] REG_FRONT_FIRE_DECEL   = 3'd6;
	localparam logic [2:0] REG_KNEE_FIRE_DECEL    = 3'd7;

	typedef enum logic [2:0] {
		MODE_OFF       = 3'd0,
		MODE_READY     = 3'd1,
		MODE_CRASH     = 3'd2,
		MODE_DEPLOYING = 3'd3,
		MODE_POST      = 3'd4,
		MODE_INOP      = 3'd5,
		MODE_SENSOR    = 3'd6,
		MODE_CIRCUIT   = 3'd7
	} mode_t;

	typedef struct packed {
		logic [14:0] front_crash_decel;
		logic [15:0] front_crash_speed;
		logic [14:0] side_crash_accel;
		logic [15:0] side_crash_speed;
		logic [14:0] rollover_rate_limit;
		logic [14:0] rollover_vertical_limit;
		logic [14:0] front_fire_decel;
		logic [14:0] knee_fire_decel;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  fault_squib;
		logic        circuit_fault_seen;
		logic        sensor_fault_seen;
		logic        passenger_belted;
		logic        passenger_present;
		logic [15:0] speed;
		logic signed [15:0] roll_rate;
		logic signed [15:0] vert_accel;
		logic signed [15:0] lat_accel;
		logic signed [15:0] long_accel;
	} sample_t;

	typedef struct packed {
		mode_t                   mode;
		logic [NUM_AIRBAGS-1:0]  deployed;
		logic [15:0]             events;
		logic [2:0]              faulty;
	} ctl_state_t;

	typedef struct packed {
		logic [NUM_AIRBAGS-1:0] fired;
		logic [NUM_AIRBAGS-1:0] inhibited;
	} fire_t;

	// Magnitude of a signed 16-bit sample, one bit wider so that -32768 fits.
	function automatic logic [16:0] mag16(input logic signed [15:0] v);
		logic [16:0] ext;
		begin
			ext = {v[15], v};
			mag16 = v[15] ? (17'd0 - ext) : ext;
		end
	endfunction

endpackage

>>> design/acdc_eval.sv
// ----------------------------------------------------------------------------
// acdc_eval: per-sample decision logic
// Latches reported faults, checks the frontal, side and rollover crash
// criteria and works out which squibs fire, giving the next controller state.
// ----------------------------------------------------------------------------
module acdc_eval import acdc_pkg::*; (
	input  cfg_t       cfg,
	input  sample_t    smp,
	input  ctl_state_t cur,
	output ctl_state_t nxt,
	output fire_t      fire
);

	mode_t       mode_a;
	logic [2:0]  faulty_a;
	logic        fault_locked;
	logic        active;
	logic        evaluate;
	logic        crash;
	logic        circuit;
	logic        lon_neg;
	logic [16:0] lon_mag;
	logic [16:0] lat_mag;
	logic [16:0] vert_mag;
	logic [16:0] roll_mag;
	logic [NUM_AIRBAGS-1:0] cmd;

	assign lon_neg  = smp.long_accel[15];
	assign lon_mag  = mag16(smp.long_accel);
	assign lat_mag  = mag16(smp.lat_accel);
	assign vert_mag = mag16(smp.vert_accel);
	assign roll_mag = mag16(smp.roll_rate);

	// Fault modes hold until reset; any other mode, post-crash included, takes
	// a new fault report.
	assign fault_locked = (cur.mode == MODE_INOP) || (cur.mode == MODE_SENSOR)
		|| (cur.mode == MODE_CIRCUIT);

	always_comb begin
		mode_a   = cur.mode;
		faulty_a = cur.faulty;
		if (!fault_locked) begin
			if (smp.sensor_fault_seen) begin
				mode_a = MODE_SENSOR;
			end else if (smp.circuit_fault_seen) begin
				mode_a   = MODE_CIRCUIT;
				faulty_a = smp.fault_squib;
			end
		end
	end

	assign active = !((mode_a == MODE_OFF) || (mode_a == MODE_INOP))
		&& !((smp.speed < LOW_SPEED_LIMIT) && (mode_a == MODE_READY));
	assign evaluate = active && ((mode_a == MODE_READY) || (mode_a == MODE_SENSOR)
		|| (mode_a == MODE_CIRCUIT));
	assign circuit = (mode_a == MODE_CIRCUIT);

	// A strict "below minus threshold" on a signed value is a negative value
	// whose magnitude exceeds the threshold.
	assign crash =
		(lon_neg && (lon_mag > {2'b00, cfg.front_crash_decel})
			&& (smp.speed > cfg.front_crash_speed))
		|| ((lat_mag > {2'b00, cfg.side_crash_accel})
			&& (smp.speed > cfg.side_crash_speed))
		|| ((roll_mag > {2'b00, cfg.rollover_rate_limit})
			&& (vert_mag > {2'b00, cfg.rollover_vertical_limit}));

	always_comb begin
		cmd = '0;
		if (lon_neg && (lon_mag > {2'b00, cfg.front_fire_decel})) begin
			cmd[BAG_DRV_FRONT] = 1'b1;
			cmd[BAG_PAS_FRONT] = smp.passenger_present && smp.passenger_belted;
			if (lon_mag > {2'b00, cfg.knee_fire_decel}) begin
				cmd[BAG_DRV_KNEE] = 1'b1;
				cmd[BAG_PAS_KNEE] = smp.passenger_present;
			end
		end
		if (smp.lat_accel > $signed(SIDE_FIRE_ACCEL)) begin
			cmd[BAG_DRV_THORAX]  = 1'b1;
			cmd[BAG_DRV_CURTAIN] = 1'b1;
		end else if (smp.lat_accel < -$signed(SIDE_FIRE_ACCEL)) begin
			cmd[BAG_PAS_THORAX]  = 1'b1;
			cmd[BAG_PAS_CURTAIN] = 1'b1;
		end
		if (roll_mag > ROLL_CURTAIN_RATE) begin
			cmd[BAG_DRV_CURTAIN] = 1'b1;
			cmd[BAG_PAS_CURTAIN] = 1'b1;
		end
	end

	always_comb begin
		nxt.mode      = mode_a;
		nxt.faulty    = faulty_a;
		nxt.deployed  = cur.deployed;
		nxt.events    = cur.events;
		fire.fired     = '0;
		fire.inhibited = '0;
		if (evaluate && crash) begin
			nxt.mode = MODE_POST;
			if (cur.events != 16'hFFFF) begin
				nxt.events = cur.events + 16'd1;
			end
			for (int k = 0; k < NUM_AIRBAGS; k++) begin
				if (cmd[k]) begin
					if (circuit && (faulty_a == k[2:0])) begin
						fire.inhibited[k] = 1'b1;
					end else if (!cur.deployed[k]) begin
						nxt.deployed[k] = 1'b1;
						fire.fired[k]   = 1'b1;
					end
				end
			end
		end
	end

endmodule

>>> design/airbag_crash_deploy_controller.sv
// ----------------------------------------------------------------------------
// airbag_crash_deploy_controller: crash detection and squib firing
// Takes one sensor sample per request and returns one status item per sample.
// ----------------------------------------------------------------------------
// Usage
// Sensor samples arrive on the s_axis channel and each produces exactly one
// status item on the m_axis channel, in order. A request is taken when tvalid
// and tready are both high. Thresholds are written on the cfg channel (index
// 0 to 7); the user must write them only while no sample is in flight, as
// the block does not enforce this. cfg_ready is always high. A sample is
// captured in an input register, then judged as it moves on to the output
// register, which shows its status; the controller state moves with it.
// One sample is accepted every cycle while the receiver keeps up; the only
// limit is the single output register.
// When the receiver stalls, the output register holds its item and the input
// register fills; s_axis_tready then drops until the output is taken.
// Reset puts the controller in ready mode with no airbag deployed, a zero
// event count and a zero faulty index, and loads the default thresholds.
// ----------------------------------------------------------------------------
module airbag_crash_deploy_controller import acdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// long_accel[15:0], lat_accel[31:16], vert_accel[47:32], roll_rate[63:48],
	// speed[79:64], passenger_present[80], passenger_belted[81],
	// sensor_fault_seen[82], circuit_fault_seen[83], fault_squib[86:84], zero[87]
	input  logic [87:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// mode[2:0], fired_now[10:3], inhibited_now[18:11], deployed_all[26:19],
	// crash_events[42:27], faulty_index[45:43], zero[47:46]
	output logic [47:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t       cfg_q;
	sample_t    smp_s1;
	logic       valid_s1;
	ctl_state_t state_q;
	ctl_state_t state_nxt;
	fire_t      fire;
	logic       out_valid_q;
	logic [47:0] out_data_q;
	logic       out_load;

	assign cfg_ready     = 1'b1;
	assign out_load      = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.front_crash_decel       <= 15'd200;
			cfg_q.front_crash_speed       <= 16'd200;
			cfg_q.side_crash_accel        <= 15'd150;
			cfg_q.side_crash_speed        <= 16'd150;
			cfg_q.rollover_rate_limit     <= 15'd1000;
			cfg_q.rollover_vertical_limit <= 15'd20;
			cfg_q.front_fire_decel        <= 15'd150;
			cfg_q.knee_fire_decel         <= 15'd250;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRONT_CRASH_DECEL: cfg_q.front_crash_decel       <= cfg_data[14:0];
				REG_FRONT_CRASH_SPEED: cfg_q.front_crash_speed       <= cfg_data;
				REG_SIDE_CRASH_ACCEL:  cfg_q.side_crash_accel        <= cfg_data[14:0];
				REG_SIDE_CRASH_SPEED:  cfg_q.side_crash_speed        <= cfg_data;
				REG_ROLLOVER_RATE:     cfg_q.rollover_rate_limit     <= cfg_data[14:0];
				REG_ROLLOVER_VERTICAL: cfg_q.rollover_vertical_limit <= cfg_data[14:0];
				REG_FRONT_FIRE_DECEL:  cfg_q.front_fire_decel        <= cfg_data[14:0];
				REG_KNEE_FIRE_DECEL:   cfg_q.knee_fire_decel         <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			smp_s1 <= sample_t'(s_axis_tdata[86:0]);
		end
	end

	acdc_eval u_eval (
		.cfg  (cfg_q),
		.smp  (smp_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.fire (fire)
	);

	// The controller state only moves when the sample leaves for the output
	// register, which keeps the samples strictly in order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode     <= MODE_READY;
			state_q.deployed <= '0;
			state_q.events   <= '0;
			state_q.faulty   <= '0;
		end else if (out_load) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {2'b00, state_nxt.faulty, state_nxt.events, state_nxt.deployed,
				fire.inhibited, fire.fired, state_nxt.mode};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

>>> bench/airbag_crash_deploy_controller_scoreboard.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// airbag_crash_deploy_controller_scoreboard: status prediction and comparison
// Watches the sample, status and threshold channels of the controller. It
// keeps its own copy of the thresholds and of the controller state, works out
// the status that each accepted sample must produce and compares every
// accepted status item, field by field, with the oldest one still awaited.
// ----------------------------------------------------------------------------
module airbag_crash_deploy_controller_scoreboard import acdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [87:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [47:0] m_axis_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          outstanding
);

	typedef struct {
		mode_t       mode;
		logic [7:0]  fired;
		logic [7:0]  inhibited;
		logic [7:0]  deployed;
		logic [15:0] events;
		logic [2:0]  faulty;
	} status_t;

	status_t     awaited_status[$];
	cfg_t        limits;
	mode_t       mode_now;
	logic [7:0]  deployed_now;
	logic [15:0] events_now;
	logic [2:0]  faulty_now;

	function automatic int magnitude(input int v);
		return (v < 0) ? -v : v;
	endfunction

	// Applies one sample to the copied state and queues the status it causes.
	task automatic judge_sample(input sample_t smp);
		int      lon;
		int      lat;
		int      vert;
		int      roll;
		int      spd;
		bit      crash;
		bit      circuit;
		logic [7:0] cmd;
		status_t st;
		lon = int'($signed(smp.long_accel));
		lat = int'($signed(smp.lat_accel));
		vert = int'($signed(smp.vert_accel));
		roll = int'($signed(smp.roll_rate));
		spd = int'(smp.speed);
		st.fired = '0;
		st.inhibited = '0;

		// Fault reports are latched unless a fault mode already holds.
		if (!(mode_now inside {MODE_INOP, MODE_SENSOR, MODE_CIRCUIT})) begin
			if (smp.sensor_fault_seen) begin
				mode_now = MODE_SENSOR;
			end else if (smp.circuit_fault_seen) begin
				faulty_now = smp.fault_squib;
				mode_now = MODE_CIRCUIT;
			end
		end

		if ((mode_now inside {MODE_SENSOR, MODE_CIRCUIT}) ||
				(mode_now == MODE_READY && spd >= int'(LOW_SPEED_LIMIT))) begin
			crash = (lon < -int'(limits.front_crash_decel) &&
					spd > int'(limits.front_crash_speed)) ||
				(magnitude(lat) > int'(limits.side_crash_accel) &&
					spd > int'(limits.side_crash_speed)) ||
				(magnitude(roll) > int'(limits.rollover_rate_limit) &&
					magnitude(vert) > int'(limits.rollover_vertical_limit));
			if (crash) begin
				circuit = (mode_now == MODE_CIRCUIT);
				if (events_now != 16'hFFFF) begin
					events_now = events_now + 16'd1;
				end
				cmd = '0;
				if (lon < -int'(limits.front_fire_decel)) begin
					cmd[BAG_DRV_FRONT] = 1'b1;
					if (smp.passenger_present && smp.passenger_belted) begin
						cmd[BAG_PAS_FRONT] = 1'b1;
					end
					if (lon < -int'(limits.knee_fire_decel)) begin
						cmd[BAG_DRV_KNEE] = 1'b1;
						if (smp.passenger_present) begin
							cmd[BAG_PAS_KNEE] = 1'b1;
						end
					end
				end
				if (lat > int'(SIDE_FIRE_ACCEL)) begin
					cmd[BAG_DRV_THORAX] = 1'b1;
					cmd[BAG_DRV_CURTAIN] = 1'b1;
				end else if (lat < -int'(SIDE_FIRE_ACCEL)) begin
					cmd[BAG_PAS_THORAX] = 1'b1;
					cmd[BAG_PAS_CURTAIN] = 1'b1;
				end
				if (magnitude(roll) > int'(ROLL_CURTAIN_RATE)) begin
					cmd[BAG_DRV_CURTAIN] = 1'b1;
					cmd[BAG_PAS_CURTAIN] = 1'b1;
				end
				// A faulty squib is reported as inhibited even when it has
				// already gone off.
				if (circuit && cmd[faulty_now]) begin
					st.inhibited[faulty_now] = 1'b1;
					cmd[faulty_now] = 1'b0;
				end
				st.fired = cmd & ~deployed_now;
				deployed_now = deployed_now | cmd;
				mode_now = MODE_POST;
			end
		end

		st.mode = mode_now;
		st.deployed = deployed_now;
		st.events = events_now;
		st.faulty = faulty_now;
		awaited_status = {awaited_status, st};
	endtask

	task automatic check_field(input string what, input longint want, input longint got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endtask

	task automatic compare_status(input logic [47:0] item);
		status_t st;
		if (awaited_status.size() == 0) begin
			fail_count++;
			$display("%0t: status 0x%h arrived with no sample awaiting it, expected none",
				$time, item);
		end else begin
			st = awaited_status.pop_front();
			check_field("mode", st.mode, item[2:0]);
			check_field("fired_now", st.fired, item[10:3]);
			check_field("inhibited_now", st.inhibited, item[18:11]);
			check_field("deployed_all", st.deployed, item[26:19]);
			check_field("crash_events", st.events, item[42:27]);
			check_field("faulty_index", st.faulty, item[45:43]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited_status.delete();
			limits = '{front_crash_decel: 15'd200, front_crash_speed: 16'd200,
				side_crash_accel: 15'd150, side_crash_speed: 16'd150,
				rollover_rate_limit: 15'd1000, rollover_vertical_limit: 15'd20,
				front_fire_decel: 15'd150, knee_fire_decel: 15'd250};
			mode_now = MODE_READY;
			deployed_now = '0;
			events_now = '0;
			faulty_now = '0;
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FRONT_CRASH_DECEL: limits.front_crash_decel = cfg_data[14:0];
					REG_FRONT_CRASH_SPEED: limits.front_crash_speed = cfg_data;
					REG_SIDE_CRASH_ACCEL: limits.side_crash_accel = cfg_data[14:0];
					REG_SIDE_CRASH_SPEED: limits.side_crash_speed = cfg_data;
					REG_ROLLOVER_RATE: limits.rollover_rate_limit = cfg_data[14:0];
					REG_ROLLOVER_VERTICAL: limits.rollover_vertical_limit = cfg_data[14:0];
					REG_FRONT_FIRE_DECEL: limits.front_fire_decel = cfg_data[14:0];
					REG_KNEE_FIRE_DECEL: limits.knee_fire_decel = cfg_data[14:0];
					default: ;
				endcase
			end
			// The status leaving now always belongs to an older sample, so it
			// is matched before the sample arriving now is queued.
			if (m_axis_tvalid && m_axis_tready) begin
				compare_status(m_axis_tdata);
			end
			if (s_axis_tvalid && s_axis_tready) begin
				judge_sample(sample_t'(s_axis_tdata[86:0]));
			end
			outstanding <= awaited_status.size();
		end
	end

endmodule

>>> bench/airbag_crash_deploy_controller_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// airbag_crash_deploy_controller_test: stimulus and verdict for the controller
// Runs a short directed sequence through every crash rule and fault path, then
// several threshold settings with random samples shaped around the active
// limits under varied sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module airbag_crash_deploy_controller_test import acdc_pkg::*;;

	localparam int PHASES           = 6;
	localparam int PHASE_ITEMS      = 172;
	localparam int LONG_HOLD        = 150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [87:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_FRONT_CRASH_DECEL;
	logic [15:0] cfg_data = '0;

	int fail_count;
	int outstanding;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_asked = 0;
	int hold_served = 0;
	int hold_left = 0;

	// Thresholds as last written, used only to aim the random samples.
	int thr_front_decel = 200;
	int thr_front_speed = 200;
	int thr_side_accel = 150;
	int thr_side_speed = 150;
	int thr_roll_rate = 1000;
	int thr_roll_vert = 20;
	int thr_front_fire = 150;
	int thr_knee_fire = 250;

	airbag_crash_deploy_controller u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	airbag_crash_deploy_controller_scoreboard u_scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Status receiver: random stalls, plus a long hold-off whenever asked.
	always @(posedge clk) begin
		if (hold_asked != hold_served) begin
			hold_served = hold_asked;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= (int'($urandom_range(99)) >= stall_pct);
		end
	end

	initial begin
		#5000000;
		$display("airbag_crash_deploy_controller_test failed");
		$finish;
	end

	function automatic sample_t mk_sample(input int lon, input int lat, input int vert,
			input int roll, input int spd, input bit present, input bit belted,
			input bit sfault, input bit cfault, input int squib);
		sample_t s;
		s.long_accel = lon[15:0];
		s.lat_accel = lat[15:0];
		s.vert_accel = vert[15:0];
		s.roll_rate = roll[15:0];
		s.speed = spd[15:0];
		s.passenger_present = present;
		s.passenger_belted = belted;
		s.sensor_fault_seen = sfault;
		s.circuit_fault_seen = cfault;
		s.fault_squib = squib[2:0];
		return s;
	endfunction

	// A value just either side of a limit, with a random sign.
	function automatic logic [15:0] around(input int level);
		int v;
		v = level + int'($urandom_range(4)) - 2;
		if ($urandom_range(1)) begin
			v = -v;
		end
		return v[15:0];
	endfunction

	function automatic logic [15:0] accel_pick(input int lvl_a, input int lvl_b);
		int v;
		case ($urandom_range(5))
			0, 1: return around(lvl_a);
			2: return around(lvl_b);
			3: return 16'($urandom);
			4: begin
				v = int'($urandom_range(600)) - 300;
				return v[15:0];
			end
			default: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
		endcase
	endfunction

	function automatic logic [15:0] speed_pick();
		int v;
		case ($urandom_range(3))
			0: return 16'($urandom_range(60));
			1: v = thr_front_speed + int'($urandom_range(4)) - 2;
			2: v = thr_side_speed + int'($urandom_range(4)) - 2;
			default: v = int'($urandom_range(65535));
		endcase
		return v[15:0];
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		s.long_accel = accel_pick(thr_front_decel,
			$urandom_range(1) ? thr_front_fire : thr_knee_fire);
		s.lat_accel = accel_pick(thr_side_accel, int'(SIDE_FIRE_ACCEL));
		s.vert_accel = accel_pick(thr_roll_vert, thr_roll_vert);
		s.roll_rate = accel_pick(thr_roll_rate, int'(ROLL_CURTAIN_RATE));
		s.speed = speed_pick();
		s.passenger_present = 1'($urandom_range(1));
		s.passenger_belted = 1'($urandom_range(1));
		// Faults are fairly common: they are what re-arms crash detection.
		s.sensor_fault_seen = (int'($urandom_range(99)) < 12);
		s.circuit_fault_seen = (int'($urandom_range(99)) < 15);
		s.fault_squib = 3'($urandom_range(7));
		return s;
	endfunction

	task automatic send_sample(input sample_t s);
		while (int'($urandom_range(99)) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, s};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic write_all(input logic [15:0] fcd, input logic [15:0] fcs,
			input logic [15:0] sca, input logic [15:0] scs, input logic [15:0] rr,
			input logic [15:0] rv, input logic [15:0] ffd, input logic [15:0] kfd);
		write_reg(REG_FRONT_CRASH_DECEL, fcd);
		write_reg(REG_FRONT_CRASH_SPEED, fcs);
		write_reg(REG_SIDE_CRASH_ACCEL, sca);
		write_reg(REG_SIDE_CRASH_SPEED, scs);
		write_reg(REG_ROLLOVER_RATE, rr);
		write_reg(REG_ROLLOVER_VERTICAL, rv);
		write_reg(REG_FRONT_FIRE_DECEL, ffd);
		write_reg(REG_KNEE_FIRE_DECEL, kfd);
		cfg_valid <= 1'b0;
		thr_front_decel = int'(fcd[14:0]);
		thr_front_speed = int'(fcs);
		thr_side_accel = int'(sca[14:0]);
		thr_side_speed = int'(scs);
		thr_roll_rate = int'(rr[14:0]);
		thr_roll_vert = int'(rv[14:0]);
		thr_front_fire = int'(ffd[14:0]);
		thr_knee_fire = int'(kfd[14:0]);
	endtask

	// Stops offering samples until every awaited status has been taken.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sequence on the reset thresholds.
		send_sample(mk_sample(0, 0, 0, 0, 100, 0, 0, 0, 0, 0));
		send_sample(mk_sample(-201, 0, 21, -1001, 49, 1, 1, 0, 0, 0));
		send_sample(mk_sample(-201, 0, 21, -1001, 50, 1, 1, 0, 0, 0));
		send_sample(mk_sample(-32768, 32767, -32768, -32768, 65535, 1, 1, 0, 0, 0));
		send_sample(mk_sample(0, 32767, 0, 0, 65535, 0, 0, 1, 0, 0));
		send_sample(mk_sample(0, -32768, 0, 0, 151, 0, 0, 0, 1, 3));
		send_sample(mk_sample(-251, 0, 0, 0, 201, 1, 0, 0, 1, 0));
		send_sample(mk_sample(0, 0, 0, 0, 300, 0, 0, 1, 1, 5));
		send_sample(mk_sample(0, 0, 0, 0, 10, 0, 0, 0, 1, 2));
		send_sample(mk_sample(-200, 150, 21, 1000, 201, 0, 0, 0, 0, 0));
		send_sample(mk_sample(-201, 0, 0, 0, 200, 0, 0, 0, 0, 0));
		send_sample(mk_sample(-201, 100, 0, 900, 201, 1, 1, 0, 0, 0));
		send_sample(mk_sample(-150, -100, 0, 0, 201, 0, 0, 1, 0, 0));
		send_sample(mk_sample(-32768, -101, 0, 0, 65535, 1, 1, 0, 0, 0));
		send_sample(mk_sample(0, 0, 0, 0, 0, 0, 0, 0, 1, 7));
		send_sample(mk_sample(0, 0, 32767, -32768, 0, 1, 0, 0, 0, 0));
		send_sample(mk_sample(32767, 0, 0, 0, 65535, 0, 0, 0, 0, 0));
		send_sample(mk_sample(-32768, 0, 0, 0, 65535, 1, 1, 1, 0, 6));
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 60; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 60; end
				default: begin send_idle_pct = 33; stall_pct = 33; end
			endcase
			case (p)
				0, 3: write_all(16'($urandom_range(20, 1500)), 16'($urandom_range(900)),
					16'($urandom_range(20, 1500)), 16'($urandom_range(900)),
					16'($urandom_range(200, 3000)), 16'($urandom_range(5, 100)),
					16'($urandom_range(20, 1500)), 16'($urandom_range(20, 1500)));
				1: write_all('0, '0, '0, '0, '0, '0, '0, '0);
				2: write_all('1, '1, '1, '1, '1, '1, '1, '1);
				4: write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
				default: write_all(16'd200, 16'd200, 16'd150, 16'd150, 16'd1000, 16'd20,
					16'd150, 16'd250);
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Hold the receiver off while samples keep coming, so that
				// the input side fills and stalls.
				if (p % 4 == 0 && i == 40) begin
					hold_asked <= hold_asked + 1;
				end
				if (i == 90) begin
					drain();
				end
				send_sample(random_sample());
			end
			drain();
		end
		repeat (4) @(posedge clk);

		if (fail_count == 0) begin
			$display("airbag_crash_deploy_controller_test passed");
		end else begin
			$display("airbag_crash_deploy_controller_test failed");
		end
		$finish;
	end

endmodule

>>> airbag_crash_deploy_controller.f
design/acdc_pkg.sv
design/acdc_eval.sv
design/airbag_crash_deploy_controller.sv
bench/airbag_crash_deploy_controller_scoreboard.sv
bench/airbag_crash_deploy_controller_test.sv
